[hw/rtl/itoa_pkg.sv]
// itoa_pkg: shared types, character codes and helpers for the integer to ascii formatter
// no dependencies; imported by the interfaces, controller, datapath and top level
`timescale 1ns / 1ps

package itoa_pkg;

	// field widths fixed by the item format
	localparam int unsigned VALUE_W  = 64;
	localparam int unsigned CHAR_W   = 7;
	localparam int unsigned WIDTH_W  = 7;
	localparam int unsigned MAX_CHARS = 64;

	// bcd conversion: 64 bits need 20 decimal digits
	localparam int unsigned DEC_DIGITS = 20;
	localparam int unsigned BCD_W      = 4 * DEC_DIGITS;
	localparam int unsigned REM_W      = $clog2(DEC_DIGITS + 1);
	localparam int unsigned BIT_CNT_W  = $clog2(VALUE_W);

	// ascii codes
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h61;
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2d;

	typedef enum logic [1:0] {
		OP_HEX  = 2'd0,
		OP_UDEC = 2'd1,
		OP_SDEC = 2'd2,
		OP_RSVD = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_DIGIT,
		ST_PAD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv_step;
		logic skip;
		logic emit_sign;
		logic emit_digit;
		logic emit_pad;
		logic last;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		opcode_t op;
		logic    neg;
		logic    conv_done;
		logic    can_skip;
		logic    last_digit;
		logic    width_reached;
		logic    out_free;
	} dp_sts_t;

	// one nibble to a lowercase hex or decimal digit character
	function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
		logic [CHAR_W-1:0] ch;
		if (d < 4'd10) begin
			ch = CH_ZERO + CHAR_W'(d);
		end else begin
			ch = CH_A + CHAR_W'(d - 4'd10);
		end
		return ch;
	endfunction

endpackage

[hw/rtl/itoa_in_if.sv]
// itoa_in_if: input channel carrying one number and its format request per beat
// depends on itoa_pkg for field widths
`timescale 1ns / 1ps

interface itoa_in_if import itoa_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [1:0]           opcode;
	logic [VALUE_W-1:0]   value;
	logic                 leading_zeros;
	logic [WIDTH_W-1:0]   min_width;

	modport source(output valid, output opcode, output value, output leading_zeros,
		output min_width, input ready);
	modport sink(input valid, input opcode, input value, input leading_zeros,
		input min_width, output ready);
endinterface

[hw/rtl/itoa_out_if.sv]
// itoa_out_if: output channel carrying one ascii character per beat
// depends on itoa_pkg for field widths
`timescale 1ns / 1ps

interface itoa_out_if import itoa_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [CHAR_W-1:0]   char_code;
	logic                last;

	modport source(output valid, output char_code, output last, input ready);
	modport sink(input valid, input char_code, input last, output ready);
endinterface

[hw/rtl/integer_to_ascii_formatter.sv]
// integer_to_ascii_formatter: top level joining the controller and the datapath
// depends on itoa_pkg, itoa_in_if, itoa_out_if, itoa_ctrl and itoa_datapath
//
//   channel  dir  beat contents
//   in_ch    in   opcode, value, leading_zeros, min_width
//   out_ch   out  char_code, last (one character per beat)
//
// hex: a load step, a skip over up to HEX_DIGITS-1 leading zero digits, a step to leave the skip,
//   then one digit per cycle while out_ch is not stalled
// decimal: a load step, serial binary to bcd shifting of all 64 bits, a skip over up to 19
//   leading zero digits, a step to leave the skip, then one character per cycle while out_ch
//   is not stalled, up to a full 64-character field
// a new number is taken only once the last character of the previous one sits in the
//   output register; a stalled out_ch holds the current character and pauses emission
// arst_n clears the state machine and the output valid flag
`timescale 1ns / 1ps

module integer_to_ascii_formatter import itoa_pkg::*; #(
	parameter int unsigned HEX_DIGITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	itoa_in_if.sink    in_ch,
	itoa_out_if.source out_ch
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequencing
	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// conversion and output
	itoa_datapath #(
		.HEX_DIGITS (HEX_DIGITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (in_ch.opcode),
		.value         (in_ch.value),
		.leading_zeros (in_ch.leading_zeros),
		.min_width     (in_ch.min_width),
		.out_ch        (out_ch)
	);

	// at most one character source per cycle
	a_one_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_sign, cmd.emit_digit, cmd.emit_pad}))
		else $error("more than one character source selected");

	// a character is only written when the output register is free
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_sign || cmd.emit_digit || cmd.emit_pad) |-> sts.out_free)
		else $error("character written over a held output beat");

	// a reserved opcode produces nothing and leaves the block ready
	a_rsvd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready && (in_ch.opcode == OP_RSVD)) |=> in_ch.ready)
		else $error("reserved opcode did not return to idle");

	// the last flag only accompanies a digit or a pad character
	a_last_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.last && (cmd.emit_sign || cmd.emit_digit || cmd.emit_pad) |-> !cmd.emit_sign)
		else $error("last flag set on a sign character");

endmodule

[hw/rtl/itoa_ctrl.sv]
// itoa_ctrl: sequencing state machine for load, conversion, zero skip and character output
// depends on itoa_pkg for state, command and status types
`timescale 1ns / 1ps

module itoa_ctrl import itoa_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (sts.op)
						OP_HEX:  state_d = ST_SKIP;
						OP_UDEC: state_d = ST_CONV;
						OP_SDEC: state_d = ST_CONV;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_CONV: begin
				if (sts.conv_done) begin
					state_d = ST_SKIP;
				end
			end
			ST_SKIP: begin
				if (!sts.can_skip) begin
					state_d = sts.neg ? ST_SIGN : ST_DIGIT;
				end
			end
			ST_SIGN: begin
				if (sts.out_free) begin
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (sts.out_free && sts.last_digit) begin
					state_d = sts.width_reached ? ST_IDLE : ST_PAD;
				end
			end
			ST_PAD: begin
				if (sts.out_free && sts.width_reached) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_CONV: cmd.conv_step = 1'b1;
			ST_SKIP: cmd.skip = sts.can_skip;
			ST_SIGN: cmd.emit_sign = sts.out_free;
			ST_DIGIT: begin
				cmd.emit_digit = sts.out_free;
				cmd.last       = sts.last_digit && sts.width_reached;
			end
			ST_PAD: begin
				cmd.emit_pad = sts.out_free;
				cmd.last     = sts.width_reached;
			end
			default: cmd = '0;
		endcase
	end

endmodule

[hw/rtl/itoa_datapath.sv]
// itoa_datapath: bit-serial binary to bcd converter, digit shift register and output register
// depends on itoa_pkg and itoa_out_if
`timescale 1ns / 1ps

module itoa_datapath import itoa_pkg::*; #(
	parameter int unsigned HEX_DIGITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_sts_t            sts,
	input  logic [1:0]         opcode,
	input  logic [VALUE_W-1:0] value,
	input  logic               leading_zeros,
	input  logic [WIDTH_W-1:0] min_width,
	itoa_out_if.source         out_ch
);

	localparam int unsigned HEX_W = 4 * HEX_DIGITS;

	opcode_t               op_q;
	logic                  neg_q;
	logic                  lead_q;
	logic [WIDTH_W-1:0]    width_q;
	logic [VALUE_W-1:0]    bin_q;
	logic [BCD_W-1:0]      bcd_q;
	logic [REM_W-1:0]      remain_q;
	logic [BIT_CNT_W-1:0]  bit_cnt_q;
	logic [WIDTH_W-1:0]    chars_q;
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	opcode_t               in_op;
	logic                  in_neg;
	logic [VALUE_W-1:0]    in_mag;
	logic [WIDTH_W-1:0]    in_width;
	logic [BCD_W-1:0]      bcd_adj;
	logic [CHAR_W-1:0]     emit_char;
	logic                  emit;

	// decode of the incoming beat
	always_comb begin
		in_op  = opcode_t'(opcode);
		in_neg = (in_op == OP_SDEC) && value[VALUE_W-1];
		in_mag = in_neg ? (VALUE_W'(0) - value) : value;
		if (in_op == OP_HEX) begin
			in_width = '0;
		end else if (min_width > WIDTH_W'(MAX_CHARS)) begin
			in_width = WIDTH_W'(MAX_CHARS);
		end else begin
			in_width = min_width;
		end
	end

	// add-3 correction on every bcd digit before the shift
	always_comb begin
		for (int i = 0; i < DEC_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// character select
	assign emit = cmd.emit_sign || cmd.emit_digit || cmd.emit_pad;
	always_comb begin
		if (cmd.emit_sign) begin
			emit_char = CH_MINUS;
		end else if (cmd.emit_digit) begin
			emit_char = digit_char(bcd_q[BCD_W-1 -: 4]);
		end else begin
			emit_char = CH_SPACE;
		end
	end

	// number registers: load, convert, skip and shift out digits
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q      <= in_op;
			neg_q     <= in_neg;
			lead_q    <= leading_zeros && (in_op == OP_HEX);
			width_q   <= in_width;
			bin_q     <= in_mag;
			bit_cnt_q <= '0;
			chars_q   <= '0;
			if (in_op == OP_HEX) begin
				bcd_q    <= {value[HEX_W-1:0], {(BCD_W-HEX_W){1'b0}}};
				remain_q <= REM_W'(HEX_DIGITS);
			end else begin
				bcd_q    <= '0;
				remain_q <= REM_W'(DEC_DIGITS);
			end
		end else if (cmd.conv_step) begin
			bcd_q     <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q     <= {bin_q[VALUE_W-2:0], 1'b0};
			bit_cnt_q <= bit_cnt_q + 1'b1;
		end else if (cmd.skip || cmd.emit_digit) begin
			bcd_q    <= {bcd_q[BCD_W-5:0], 4'h0};
			remain_q <= remain_q - 1'b1;
		end
		if (emit) begin
			chars_q <= chars_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			char_q <= emit_char;
			last_q <= cmd.last;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.char_code = char_q;
	assign out_ch.last      = last_q;

	// status back to the controller
	always_comb begin
		sts.op            = cmd.load ? in_op : op_q;
		sts.neg           = neg_q;
		sts.conv_done     = (bit_cnt_q == {BIT_CNT_W{1'b1}});
		sts.can_skip      = (bcd_q[BCD_W-1 -: 4] == 4'h0) && (remain_q != REM_W'(1)) && !lead_q;
		sts.last_digit    = (remain_q == REM_W'(1));
		sts.width_reached = ({1'b0, chars_q} + 1'b1) >= {1'b0, width_q};
		sts.out_free      = !out_valid_q || out_ch.ready;
	end

endmodule
